// ----- hdl/lfa_pkg.sv -----
// Shared constants and payload types of the lowest free ID allocator.
`default_nettype none

package lfa_pkg;

	// Default width of an ID; the ID space is 1 to 2^ID_BITS-1.
	localparam int ID_BITS_DEFAULT = 8;

	// Bitmap words are at most 2^WORD_LOG_MAX bits wide.
	localparam int WORD_LOG_MAX = 4;

	// Width of the ID fields on the channels.
	localparam int VALUE_BITS = 8;

	// Item kinds carried in the mode field.
	localparam logic MODE_CLAIM = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	typedef struct packed {
		logic                  mode;
		logic [VALUE_BITS-1:0] claim_value;
	} lfa_in_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] granted_id;
		logic                  wrapped;
	} lfa_out_t;

endpackage

`default_nettype wire

// ----- hdl/lfa_stream_if.sv -----
// Valid/ready stream interface that carries one payload per transaction.
`default_nettype none

interface lfa_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lfa_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module lfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/lowest_free_id_allocator.sv -----
// Lowest free ID allocator: bitmap of claimed IDs kept in a word-wide RAM.
// Each request is taken in the idle state, which reads its bitmap word; in the read state the
// result is registered, while an allocate first scans on word by word past every fully
// claimed bitmap word. One item is in flight at a time; a held result stalls the next item.
// The scan pointer only moves up between wraps, so each word is stepped over once per wrap.
// Reset: a clearing pass writes every bitmap word, and requests are held off until it is
// done; a wrap needs no pass.
`default_nettype none

module lowest_free_id_allocator #(
	parameter int ID_BITS = lfa_pkg::ID_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lfa_stream_if.sink       req,
	lfa_stream_if.source     rsp
);

	// The bitmap is cut into words of WORD_BITS IDs. Narrow ID spaces still get
	// two words so that the word address is never empty.
	localparam int WORD_LOG  = (ID_BITS - 1 < lfa_pkg::WORD_LOG_MAX) ?
	                           ID_BITS - 1 : lfa_pkg::WORD_LOG_MAX;
	localparam int WORD_BITS = 1 << WORD_LOG;
	localparam int ADDR_BITS = ID_BITS - WORD_LOG;
	localparam int DEPTH     = 1 << ADDR_BITS;
	localparam int RAM_W     = WORD_BITS + 1;
	localparam int VB        = lfa_pkg::VALUE_BITS;

	// Controller states.
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]           state_q;
	logic [ADDR_BITS-1:0] clr_q;
	logic [ADDR_BITS-1:0] lo_q;
	logic                 epoch_q;
	logic                 alloc_q;
	logic                 ok_q;
	logic [ID_BITS-1:0]   id_q;
	logic                 rsp_valid_q;
	lfa_pkg::lfa_out_t    rsp_data_q;
	lfa_pkg::lfa_out_t    pend_q;

	logic                 wr_en;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [RAM_W-1:0]     wr_data;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [RAM_W-1:0]     rd_data;

	logic                 accept;
	logic                 slot_free;
	logic [ID_BITS+VB-1:0] claim_ext;
	logic [ID_BITS-1:0]   claim_num;
	logic                 claim_ok;
	logic [WORD_BITS-1:0] eff;
	logic [WORD_BITS-1:0] free;
	logic [WORD_LOG-1:0]  zbit;
	logic                 full;
	logic                 last;
	logic                 scan;
	logic                 wrap;
	logic [WORD_BITS-1:0] claim_word;
	logic [WORD_BITS-1:0] alloc_word;
	logic [ID_BITS-1:0]   alloc_id;
	lfa_pkg::lfa_out_t    res;

	lfa_ram #(
		.WIDTH (RAM_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;

	// A claim of zero or of a value beyond the ID space leaves the bitmap alone.
	assign claim_ext = (ID_BITS + VB)'(req.data.claim_value);
	assign claim_num = claim_ext[ID_BITS-1:0];
	assign claim_ok  = (claim_num != '0) && (claim_ext[ID_BITS+VB-1:ID_BITS] == '0);

	// Each word carries an epoch bit. A wrap flips the current epoch, which makes
	// every stored word read as empty without touching the RAM. This is sound
	// because a wrap only happens once every word was written in the old epoch.
	assign eff = (rd_data[WORD_BITS] == epoch_q) ? rd_data[WORD_BITS-1:0] : '0;

	always_comb begin
		free = ~eff;
		if (lo_q == '0) begin
			free[0] = 1'b0;
		end
		zbit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free[i]) begin
				zbit = WORD_LOG'(i);
			end
		end
	end

	assign full       = (free == '0);
	assign last       = (lo_q == '1);
	assign scan       = (state_q == ST_READ) && alloc_q && full && !last;
	assign wrap       = alloc_q && full && last;
	assign claim_word = eff | (WORD_BITS'(1) << id_q[WORD_LOG-1:0]);
	assign alloc_word = eff | (WORD_BITS'(1) << zbit);
	assign alloc_id   = {lo_q, zbit};

	// Read side: the word of a new item at acceptance, the next word while scanning.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = lo_q;
		if (accept) begin
			rd_en = 1'b1;
			if (req.data.mode == lfa_pkg::MODE_CLAIM) begin
				rd_addr = claim_num[ID_BITS-1:WORD_LOG];
			end
		end else if (scan) begin
			rd_en   = 1'b1;
			rd_addr = lo_q + ADDR_BITS'(1);
		end
	end

	// Write side: the clearing pass, or the single write-back of an item.
	// Only one item is in flight, so a write always lands before the next read.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == ST_READ && !scan) begin
			if (wrap) begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {~epoch_q, WORD_BITS'(2)};
			end else if (alloc_q) begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = {epoch_q, alloc_word};
			end else begin
				wr_en   = ok_q;
				wr_addr = id_q[ID_BITS-1:WORD_LOG];
				wr_data = {epoch_q, claim_word};
			end
		end
	end

	// Result of the item that finishes in this cycle.
	always_comb begin
		res.granted_id = '0;
		res.wrapped    = 1'b0;
		if (wrap) begin
			res.granted_id = VB'(1);
			res.wrapped    = 1'b1;
		end else if (alloc_q) begin
			res.granted_id = VB'(alloc_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			lo_q        <= '0;
			epoch_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_BITS'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (scan) begin
						lo_q <= lo_q + ADDR_BITS'(1);
					end else begin
						if (wrap) begin
							lo_q    <= '0;
							epoch_q <= ~epoch_q;
						end
						if (slot_free) begin
							rsp_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			alloc_q <= (req.data.mode == lfa_pkg::MODE_ALLOC);
			ok_q    <= claim_ok;
			id_q    <= claim_num;
		end
		if (state_q == ST_READ && !scan) begin
			if (slot_free) begin
				rsp_data_q <= res;
			end else begin
				pend_q <= res;
			end
		end
		if (state_q == ST_WAIT && slot_free) begin
			rsp_data_q <= pend_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

`default_nettype wire

// ----- hdl/lfa_checker.sv -----
// Port-level assertions for the lowest free ID allocator and their bind.
`default_nettype none

module lfa_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire lfa_pkg::lfa_out_t rsp_data
);

	logic [1:0] open_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Requests taken minus results delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped or changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 2'd0)
		else $error("result shown with no request outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("more than two requests in flight");

	a_wrap_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.wrapped |-> rsp_data.granted_id == lfa_pkg::VALUE_BITS'(1))
		else $error("wrapped result does not grant ID one");

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
